>>> sv/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

    localparam int NODE_W      = 4;
    localparam int NODE_IDS    = 16;
    localparam int STACK_DEPTH = 16;
    localparam int MAX_NODES   = 16;
    localparam int MAX_EDGES   = 64;
    localparam int CNT_W       = $clog2(MAX_EDGES + 1);
    localparam int NC_W        = 5;
    localparam int PADDR_W     = 3;

    localparam logic [NC_W-1:0] NODE_LIMIT =
        NC_W'((MAX_NODES < NODE_IDS) ? MAX_NODES : NODE_IDS);

    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CYCLE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DEG_PEEK,
        DEG_INC,
        DEG_DEC
    } t_deg_op;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              node_valid;
        logic              last;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
    } t_edge;

    typedef struct packed {
        logic              valid;
        t_deg_op           op;
        logic [NODE_W-1:0] node;
    } t_deg_req;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } t_push;

endpackage

>>> sv/dependency_topological_sort.sv
`timescale 1ns / 1ps

// Orders the nodes of a dependency graph with a stack-based Kahn sort.
// Input transactions carry either an edge load (from_node -> to_node) or a
// resolve command. Loads are taken one per cycle and written into the edge
// memory; once the memory is full further edges are dropped and flagged.
// A resolve counts in-degrees over the edge memory, scans nodes below
// node_count, capped at NODE_LIMIT, for zero in-degree, and then for each
// popped node emits one output transaction and walks the edge memory again.
// A final transaction with last set carries the status: ok, cycle or overflow.
// Input is stalled from the resolve until its status transaction is in the
// output register. The output register holds its transaction while the
// receiver stalls, and the sort waits for it.
// Reset empties the edge list and clears node_count; the in-degree table
// reads zero through per-entry valid bits, so no clearing pass is needed.
// node_count is written over the APB port at address 0.
module dependency_topological_sort #(
    parameter int MAX_EDGES = dts_pkg::MAX_EDGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dts_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dts_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dts_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int SPW = $clog2(dts_pkg::STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_SCAN,
        S_POP,
        S_WALK,
        S_STATUS
    } t_state;

    t_state                     r_state, n_state;
    logic [ETW-1:0]             r_total, n_total;
    logic                       r_overflow, n_overflow;
    logic [dts_pkg::NC_W-1:0]   r_node_count;
    logic [ETW-1:0]             r_idx, n_idx;
    logic                       r_e_valid, n_e_valid;
    logic [dts_pkg::NC_W-1:0]   r_scan, n_scan;
    logic [dts_pkg::NODE_W-1:0] r_node, n_node;
    logic [SPW-1:0]             r_sp, n_sp;
    logic [ETW-1:0]             r_dec_cnt, n_dec_cnt;
    logic                       r_out_valid, n_out_valid;
    dts_pkg::t_out_item         r_out_data, n_out_data;
    logic [dts_pkg::NODE_W-1:0] r_stack [dts_pkg::STACK_DEPTH];

    logic                       w_slot_free;
    logic                       w_edge_we;
    dts_pkg::t_edge             w_wedge;
    dts_pkg::t_edge             w_edge;
    dts_pkg::t_deg_req          w_req;
    dts_pkg::t_push             w_push;
    logic                       w_busy;
    logic                       w_clear;
    logic [dts_pkg::NC_W-1:0]   w_limit;
    logic [dts_pkg::NODE_W-1:0] w_top;
    logic                       w_cfg_we;

    assign w_wedge.src = i_in_data.from_node;
    assign w_wedge.dst = i_in_data.to_node;

    dts_ram #(
        .WIDTH ($bits(dts_pkg::t_edge)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (r_total[EAW-1:0]),
        .i_wdata (w_wedge),
        .i_raddr (r_idx[EAW-1:0]),
        .o_rdata (w_edge)
    );

    dts_indeg #(
        .CNT_W (CW)
    ) u_indeg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_req   (w_req),
        .o_push  (w_push),
        .o_busy  (w_busy)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign pready      = 1'b1;
    assign w_cfg_we    = psel && penable && pwrite && paddr[2] == dts_pkg::REG_NODE_COUNT;
    assign prdata      = (paddr[2] == dts_pkg::REG_NODE_COUNT) ?
                         {{(32 - dts_pkg::NC_W){1'b0}}, r_node_count} : '0;
    assign w_limit     = (r_node_count > dts_pkg::NODE_LIMIT) ?
                         dts_pkg::NODE_LIMIT : r_node_count;
    assign w_top       = r_sp[dts_pkg::NODE_W-1:0] - 1'b1;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_overflow  = r_overflow;
        n_idx       = r_idx;
        n_e_valid   = 1'b0;
        n_scan      = r_scan;
        n_node      = r_node;
        n_sp        = r_sp;
        n_dec_cnt   = r_dec_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_edge_we   = 1'b0;
        w_clear     = 1'b0;
        w_req       = '0;

        if (r_e_valid) begin
            if (r_state == S_BUILD) begin
                w_req.valid = 1'b1;
                w_req.op    = dts_pkg::DEG_INC;
                w_req.node  = w_edge.dst;
            end else if (w_edge.src == r_node) begin
                w_req.valid = 1'b1;
                w_req.op    = dts_pkg::DEG_DEC;
                w_req.node  = w_edge.dst;
                n_dec_cnt   = r_dec_cnt + 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == dts_pkg::ACT_LOAD) begin
                        if (r_total < ETW'(MAX_EDGES)) begin
                            w_edge_we = 1'b1;
                            n_total   = r_total + 1'b1;
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else begin
                        n_idx     = '0;
                        n_dec_cnt = '0;
                        n_sp      = '0;
                        n_state   = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (r_idx < r_total) begin
                    n_e_valid = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else if (!r_e_valid) begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan < w_limit) begin
                    w_req.valid = 1'b1;
                    w_req.op    = dts_pkg::DEG_PEEK;
                    w_req.node  = r_scan[dts_pkg::NODE_W-1:0];
                    n_scan      = r_scan + 1'b1;
                end else if (!w_busy) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_STATUS;
                end else if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.node_index = r_stack[w_top];
                    n_out_data.node_valid = 1'b1;
                    n_out_data.last       = 1'b0;
                    n_out_data.status     = dts_pkg::ST_OK;
                    n_sp                  = r_sp - 1'b1;
                    n_node                = r_stack[w_top];
                    n_idx                 = '0;
                    n_state               = S_WALK;
                end
            end
            S_WALK: begin
                if (r_idx < r_total) begin
                    n_e_valid = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else if (!r_e_valid && !w_busy) begin
                    n_state = S_POP;
                end
            end
            S_STATUS: begin
                if (w_slot_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.node_index = '0;
                    n_out_data.node_valid = 1'b0;
                    n_out_data.last       = 1'b1;
                    if (r_overflow) begin
                        n_out_data.status = dts_pkg::ST_OVERFLOW;
                    end else if (r_dec_cnt != r_total) begin
                        n_out_data.status = dts_pkg::ST_CYCLE;
                    end else begin
                        n_out_data.status = dts_pkg::ST_OK;
                    end
                    n_total    = '0;
                    n_overflow = 1'b0;
                    n_sp       = '0;
                    w_clear    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_push.valid && r_sp < SPW'(dts_pkg::STACK_DEPTH)) begin
            n_sp = r_sp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_scan     <= n_scan;
        r_node     <= n_node;
        r_dec_cnt  <= n_dec_cnt;
        r_out_data <= n_out_data;
        if (w_push.valid && r_sp < SPW'(dts_pkg::STACK_DEPTH)) begin
            r_stack[r_sp[dts_pkg::NODE_W-1:0]] <= w_push.node;
        end
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_overflow   <= 1'b0;
            r_e_valid    <= 1'b0;
            r_sp         <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= '0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_overflow  <= n_overflow;
            r_e_valid   <= n_e_valid;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            if (w_cfg_we) begin
                r_node_count <= pwdata[dts_pkg::NC_W-1:0];
            end
        end
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(dts_pkg::STACK_DEPTH))
        else $error("Ready stack pointer exceeds the stack depth.");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (!w_busy && !r_e_valid))
        else $error("Pop attempted while in-degree updates are in flight.");

    a_dec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_dec_cnt <= r_total))
        else $error("More edges removed than were loaded.");

    a_status_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS && w_slot_free) |=>
            (r_state == S_IDLE && r_total == '0 && !r_overflow && r_out_data.last))
        else $error("Status transaction did not end the resolve cleanly.");

endmodule

>>> sv/dts_ram.sv
`timescale 1ns / 1ps

module dts_ram #(
    parameter int WIDTH = dts_pkg::NODE_W,
    parameter int DEPTH = dts_pkg::MAX_EDGES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/dts_indeg.sv
`timescale 1ns / 1ps

module dts_indeg #(
    parameter int CNT_W = dts_pkg::CNT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  dts_pkg::t_deg_req i_req,
    output dts_pkg::t_push    o_push,
    output logic              o_busy
);

    logic                        r_b_valid;
    dts_pkg::t_deg_op            r_b_op;
    logic [dts_pkg::NODE_W-1:0]  r_b_node;
    logic                        r_fw_valid;
    logic [dts_pkg::NODE_W-1:0]  r_fw_node;
    logic [CNT_W-1:0]            r_fw_data;
    logic [dts_pkg::NODE_IDS-1:0] r_vld;

    logic [CNT_W-1:0] w_rdata;
    logic [CNT_W-1:0] w_cur;
    logic [CNT_W-1:0] w_new;
    logic             w_we;

    dts_ram #(
        .WIDTH (CNT_W),
        .DEPTH (dts_pkg::NODE_IDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_b_node),
        .i_wdata (w_new),
        .i_raddr (i_req.node),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (r_fw_valid && r_fw_node == r_b_node) begin
            w_cur = r_fw_data;
        end else if (r_vld[r_b_node]) begin
            w_cur = w_rdata;
        end else begin
            w_cur = '0;
        end
        case (r_b_op)
            dts_pkg::DEG_INC: w_new = w_cur + 1'b1;
            dts_pkg::DEG_DEC: w_new = w_cur - 1'b1;
            default:          w_new = w_cur;
        endcase
        w_we = r_b_valid && r_b_op != dts_pkg::DEG_PEEK;
        o_push.node  = r_b_node;
        o_push.valid = r_b_valid &&
            ((r_b_op == dts_pkg::DEG_PEEK && w_cur == '0) ||
             (r_b_op == dts_pkg::DEG_DEC && w_cur == CNT_W'(1)));
    end

    assign o_busy = r_b_valid;

    always_ff @(posedge i_clk) begin
        r_b_op    <= i_req.op;
        r_b_node  <= i_req.node;
        r_fw_node <= r_b_node;
        r_fw_data <= w_new;
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_vld      <= '0;
        end else begin
            r_b_valid  <= i_req.valid;
            r_fw_valid <= w_we && !i_clear;
            if (i_clear) begin
                r_vld <= '0;
            end else if (w_we) begin
                r_vld[r_b_node] <= 1'b1;
            end
        end
    end

endmodule

>>> test/dts_order_checker.sv
`timescale 1ns / 1ps

module dts_order_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  dts_pkg::t_in_item           i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  dts_pkg::t_out_item          i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [dts_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    input  logic                        i_pready,
    output int                          o_pending,
    output int                          o_fail_count
);

    logic [dts_pkg::NODE_W-1:0] edge_src [dts_pkg::MAX_EDGES];
    logic [dts_pkg::NODE_W-1:0] edge_dst [dts_pkg::MAX_EDGES];
    logic                       edge_live [dts_pkg::MAX_EDGES];
    int                         edge_cnt = 0;
    logic                       store_overflowed = 1'b0;
    logic [dts_pkg::NC_W-1:0]   node_count_reg = '0;
    dts_pkg::t_out_item         expected_order_q [$];
    int                         fail_total = 0;

    function automatic logic no_live_inbound(input logic [dts_pkg::NODE_W-1:0] node);
        for (int e = 0; e < edge_cnt; e++) begin
            if (edge_live[e] && edge_dst[e] == node) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_sort_order();
        logic [dts_pkg::NODE_W-1:0] ready [dts_pkg::STACK_DEPTH];
        int                         depth;
        int                         emitted;
        int                         live_left;
        int                         scan;
        logic [dts_pkg::NODE_W-1:0] node;
        dts_pkg::t_out_item         res;
        dts_pkg::t_status           st;
        for (int e = 0; e < edge_cnt; e++) begin
            edge_live[e] = 1'b1;
        end
        live_left = edge_cnt;
        depth = 0;
        emitted = 0;
        scan = (node_count_reg > dts_pkg::NODE_LIMIT) ? int'(dts_pkg::NODE_LIMIT)
                                                      : int'(node_count_reg);
        for (int n = 0; n < scan; n++) begin
            if (no_live_inbound(dts_pkg::NODE_W'(n)) && depth < dts_pkg::STACK_DEPTH) begin
                ready[depth] = dts_pkg::NODE_W'(n);
                depth++;
            end
        end
        while (depth > 0 && emitted < dts_pkg::NODE_IDS) begin
            depth--;
            node = ready[depth];
            res.node_index = node;
            res.node_valid = 1'b1;
            res.last = 1'b0;
            res.status = dts_pkg::ST_OK;
            expected_order_q.push_back(res);
            emitted++;
            for (int e = 0; e < edge_cnt; e++) begin
                if (edge_live[e] && edge_src[e] == node) begin
                    edge_live[e] = 1'b0;
                    live_left--;
                    if (no_live_inbound(edge_dst[e]) && depth < dts_pkg::STACK_DEPTH) begin
                        ready[depth] = edge_dst[e];
                        depth++;
                    end
                end
            end
        end
        if (store_overflowed) begin
            st = dts_pkg::ST_OVERFLOW;
        end else if (live_left != 0) begin
            st = dts_pkg::ST_CYCLE;
        end else begin
            st = dts_pkg::ST_OK;
        end
        res.node_index = '0;
        res.node_valid = 1'b0;
        res.last = 1'b1;
        res.status = st;
        expected_order_q.push_back(res);
        for (int e = 0; e < dts_pkg::MAX_EDGES; e++) begin
            edge_live[e] = 1'b0;
        end
        edge_cnt = 0;
        store_overflowed = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        dts_pkg::t_out_item want;
        if (!i_rst_n) begin
            edge_cnt = 0;
            store_overflowed = 1'b0;
            node_count_reg = '0;
            expected_order_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == dts_pkg::PADDR_W'(4 * dts_pkg::REG_NODE_COUNT)) begin
                node_count_reg = i_pwdata[dts_pkg::NC_W-1:0];
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_order_q.size() == 0) begin
                    $error("output transaction with nothing expected: node_index %0d",
                           i_out_data.node_index);
                    fail_total++;
                end else begin
                    want = expected_order_q.pop_front();
                    if (i_out_data.node_index !== want.node_index) begin
                        $error("node_index: expected %0d, actual %0d",
                               want.node_index, i_out_data.node_index);
                        fail_total++;
                    end
                    if (i_out_data.node_valid !== want.node_valid) begin
                        $error("node_valid: expected %0d, actual %0d",
                               want.node_valid, i_out_data.node_valid);
                        fail_total++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $error("last: expected %0d, actual %0d",
                               want.last, i_out_data.last);
                        fail_total++;
                    end
                    if (i_out_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_data.status);
                        fail_total++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.action == dts_pkg::ACT_RESOLVE) begin
                    predict_sort_order();
                end else if (edge_cnt < dts_pkg::MAX_EDGES) begin
                    edge_src[edge_cnt] = i_in_data.from_node;
                    edge_dst[edge_cnt] = i_in_data.to_node;
                    edge_live[edge_cnt] = 1'b0;
                    edge_cnt++;
                end else begin
                    store_overflowed = 1'b1;
                end
            end
        end
        o_pending <= expected_order_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> test/tb_dependency_topological_sort.sv
`timescale 1ns / 1ps

module tb_dependency_topological_sort;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 100;

    typedef enum int {
        PH_DAG,
        PH_NOISE,
        PH_FULL
    } t_phase_kind;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    dts_pkg::t_in_item           in_data = '0;
    logic                        out_stall = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [dts_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic                        hold_off_req = 1'b0;
    logic                        sender_calm = 1'b0;

    logic                        in_stall;
    logic                        out_valid;
    dts_pkg::t_out_item          out_data;
    logic [31:0]                 prdata;
    logic                        pready;
    int                          pending;
    int                          fail_count;
    int                          items_sent = 0;
    int                          cycle_cnt = 0;

    dependency_topological_sort DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dts_order_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        int   run_left;
        int   mode_left;
        int   r;
        logic calm;
        logic hold_done;
        run_left = 0;
        mode_left = 0;
        calm = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                out_stall <= 1'b1;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    calm = ($urandom_range(0, 9) < 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                if (run_left > 0) begin
                    run_left--;
                end else if (!calm) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) begin
                        run_left = $urandom_range(1, 3);
                    end else if (r < 19) begin
                        run_left = $urandom_range(8, 30);
                    end
                end
                out_stall <= (run_left > 0);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (sender_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    task automatic drive_item(input dts_pkg::t_in_item item);
        int gap;
        in_data <= item;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drive_fields(input logic action, input logic [3:0] src,
                                input logic [3:0] dst);
        dts_pkg::t_in_item item;
        item.action = action;
        item.from_node = src;
        item.to_node = dst;
        drive_item(item);
    endtask

    task automatic set_node_count(input logic [dts_pkg::NC_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dts_pkg::PADDR_W'(4 * dts_pkg::REG_NODE_COUNT);
        pwdata <= {27'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input t_phase_kind kind);
        logic [dts_pkg::NODE_W-1:0] perm [dts_pkg::NODE_IDS];
        logic [dts_pkg::NODE_W-1:0] tmp;
        int                         loads;
        int                         a;
        int                         b;
        dts_pkg::t_in_item          item;
        for (int i = 0; i < dts_pkg::NODE_IDS; i++) begin
            perm[i] = dts_pkg::NODE_W'(i);
        end
        for (int i = dts_pkg::NODE_IDS - 1; i > 0; i--) begin
            a = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[a];
            perm[a] = tmp;
        end
        case (kind)
            PH_FULL: begin
                loads = dts_pkg::MAX_EDGES + $urandom_range(1, 4);
            end
            PH_NOISE: begin
                loads = $urandom_range(0, 10);
            end
            default: begin
                loads = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
            end
        endcase
        sender_calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < loads; k++) begin
            item.action = dts_pkg::ACT_LOAD;
            if (kind == PH_DAG && $urandom_range(0, 19) != 0) begin
                a = $urandom_range(0, dts_pkg::NODE_IDS - 2);
                b = $urandom_range(a + 1, dts_pkg::NODE_IDS - 1);
                item.from_node = perm[a];
                item.to_node = perm[b];
            end else if (kind == PH_FULL && k == 0) begin
                item.from_node = perm[0];
                item.to_node = perm[0];
            end else begin
                item.from_node = dts_pkg::NODE_W'($urandom());
                item.to_node = dts_pkg::NODE_W'($urandom());
            end
            drive_item(item);
        end
        item.action = dts_pkg::ACT_RESOLVE;
        item.from_node = dts_pkg::NODE_W'($urandom());
        item.to_node = dts_pkg::NODE_W'($urandom());
        drive_item(item);
    endtask

    initial begin
        int                       phase;
        int                       random_goal;
        logic [dts_pkg::NC_W-1:0] nc;
        t_phase_kind              kind;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // An empty store with nothing in the scan yields only the status.
        set_node_count(5'd0);
        drive_fields(dts_pkg::ACT_RESOLVE, 4'd0, 4'd0);

        set_node_count(5'd16);
        drive_fields(dts_pkg::ACT_LOAD, 4'd0, 4'd15);
        drive_fields(dts_pkg::ACT_LOAD, 4'd15, 4'd8);
        drive_fields(dts_pkg::ACT_LOAD, 4'd8, 4'd1);
        drive_fields(dts_pkg::ACT_LOAD, 4'd2, 4'd1);
        drive_fields(dts_pkg::ACT_LOAD, 4'd10, 4'd5);
        drive_fields(dts_pkg::ACT_RESOLVE, 4'd15, 4'd15);

        // A count above the node range saturates; the self loop is a cycle.
        set_node_count(5'd31);
        drive_fields(dts_pkg::ACT_LOAD, 4'd3, 4'd3);
        drive_fields(dts_pkg::ACT_LOAD, 4'd0, 4'd1);
        drive_fields(dts_pkg::ACT_RESOLVE, 4'd7, 4'd9);

        // Targets above the scan range still come out once freed.
        set_node_count(5'd4);
        drive_fields(dts_pkg::ACT_LOAD, 4'd0, 4'd9);
        drive_fields(dts_pkg::ACT_LOAD, 4'd9, 4'd12);
        drive_fields(dts_pkg::ACT_LOAD, 4'd1, 4'd9);
        drive_fields(dts_pkg::ACT_LOAD, 4'd12, 4'd14);
        drive_fields(dts_pkg::ACT_RESOLVE, 4'd0, 4'd15);

        // Every node free gives the longest run of results.
        set_node_count(5'd16);
        drive_fields(dts_pkg::ACT_RESOLVE, 4'd15, 4'd0);

        random_goal = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < random_goal || phase < 5) begin
            if (phase % 3 == 0) begin
                case ($urandom_range(0, 5))
                    0: nc = 5'd0;
                    1: nc = 5'd16;
                    2: nc = 5'd31;
                    3: nc = 5'd1;
                    default: nc = dts_pkg::NC_W'($urandom_range(0, 31));
                endcase
                set_node_count(phase == 0 ? 5'd16 : nc);
            end
            if (phase == 1) begin
                hold_off_req <= 1'b1;
            end
            if (phase == 4) begin
                kind = PH_FULL;
            end else if (phase == 1 || $urandom_range(0, 3) != 0) begin
                kind = PH_DAG;
            end else begin
                kind = PH_NOISE;
            end
            run_phase(kind);
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
